/* rtl/afd_pkg.sv */
// ----------------------------------------------------------------------------
// afd_pkg
// Shared types and constants for the API frame deframer with checksum.
// ----------------------------------------------------------------------------
package afd_pkg;

    // Parser phase; unused codes behave as hunting
    typedef enum logic [2:0] {
        PH_HUNT   = 3'd0,
        PH_LEN_LO = 3'd1,
        PH_LEN_HI = 3'd2,
        PH_TYPE   = 3'd3,
        PH_BODY   = 3'd4
    } t_phase;

    // Kind tag carried with each passed-on byte
    localparam logic [1:0] KIND_TYPE    = 2'd0;
    localparam logic [1:0] KIND_PAYLOAD = 2'd1;
    localparam logic [1:0] KIND_CLOSE   = 2'd2;

    // Register map (word index)
    localparam logic REG_START_BYTE = 1'b0;

    // Reset value of the start byte register
    localparam logic [7:0] START_BYTE_RST = 8'd126;

    // Checksum base: the sum plus the checksum byte makes this value
    localparam logic [7:0] CHK_BASE = 8'hFF;

    // One result item
    typedef struct packed {
        logic [7:0] data;
        logic [1:0] kind;
        logic       last;
        logic       good;
    } t_result;

endpackage

/* rtl/afd_cfg.sv */
// ----------------------------------------------------------------------------
// afd_cfg
// APB register block holding the start byte.
// ----------------------------------------------------------------------------
module afd_cfg (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    output logic [7:0]  o_start_byte
);

    logic [7:0] r_start_byte;
    logic       wr_en;

    // Decode a completed write to the start byte register
    assign wr_en  = psel && penable && pwrite && (paddr[2] == afd_pkg::REG_START_BYTE);
    assign pready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_start_byte <= afd_pkg::START_BYTE_RST;
        end else if (wr_en) begin
            r_start_byte <= pwdata[7:0];
        end
    end

    // Return the register on reads, zero beyond the map
    always_comb begin
        prdata = '0;
        if (paddr[2] == afd_pkg::REG_START_BYTE) begin
            prdata = {24'd0, r_start_byte};
        end
    end

    assign o_start_byte = r_start_byte;

endmodule

/* rtl/afd_parse.sv */
// ----------------------------------------------------------------------------
// afd_parse
// Frame parser: hunts for the start byte, reads the length, tags the type,
// payload and checksum bytes and checks the running sum.
// ----------------------------------------------------------------------------
module afd_parse (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_accept,
    input  logic [7:0]        i_byte,
    input  logic [7:0]        i_start_byte,
    output logic              o_res_valid,
    output afd_pkg::t_result  o_res
);

    afd_pkg::t_phase r_phase, n_phase;
    logic [15:0]     r_remaining, n_remaining;
    logic [7:0]      r_sum, n_sum;
    logic [7:0]      expect_chk;

    assign expect_chk = afd_pkg::CHK_BASE - r_sum;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= afd_pkg::PH_HUNT;
            r_remaining <= '0;
            r_sum       <= '0;
        end else begin
            r_phase     <= n_phase;
            r_remaining <= n_remaining;
            r_sum       <= n_sum;
        end
    end

    // Advance the phase and build the result for an accepted item
    always_comb begin
        n_phase      = r_phase;
        n_remaining  = r_remaining;
        n_sum        = r_sum;
        o_res_valid  = 1'b0;
        o_res.data   = i_byte;
        o_res.kind   = afd_pkg::KIND_TYPE;
        o_res.last   = 1'b0;
        o_res.good   = 1'b0;
        if (i_accept) begin
            case (r_phase)
                afd_pkg::PH_LEN_LO: begin
                    n_remaining = {8'd0, i_byte};
                    n_phase     = afd_pkg::PH_LEN_HI;
                end
                afd_pkg::PH_LEN_HI: begin
                    n_remaining = {i_byte, r_remaining[7:0]};
                    n_phase     = afd_pkg::PH_TYPE;
                end
                afd_pkg::PH_TYPE: begin
                    o_res_valid = 1'b1;
                    if (r_remaining == 16'd0) begin
                        // zero length: the type byte closes the frame
                        o_res.kind = afd_pkg::KIND_CLOSE;
                        o_res.last = 1'b1;
                        o_res.good = (i_byte == 8'd0);
                        n_phase    = afd_pkg::PH_HUNT;
                    end else begin
                        n_sum   = i_byte;
                        n_phase = afd_pkg::PH_BODY;
                    end
                end
                afd_pkg::PH_BODY: begin
                    o_res_valid = 1'b1;
                    if (r_remaining <= 16'd1) begin
                        o_res.kind  = afd_pkg::KIND_CLOSE;
                        o_res.last  = 1'b1;
                        o_res.good  = (expect_chk == i_byte);
                        n_remaining = '0;
                        n_phase     = afd_pkg::PH_HUNT;
                    end else begin
                        o_res.kind  = afd_pkg::KIND_PAYLOAD;
                        n_sum       = r_sum + i_byte;
                        n_remaining = r_remaining - 16'd1;
                    end
                end
                default: begin
                    // hunt: drop bytes until the start byte
                    n_phase = afd_pkg::PH_HUNT;
                    if (i_byte == i_start_byte) begin
                        n_phase     = afd_pkg::PH_LEN_LO;
                        n_remaining = '0;
                        n_sum       = '0;
                    end
                end
            endcase
        end
    end

endmodule

/* rtl/afd_skid.sv */
// ----------------------------------------------------------------------------
// afd_skid
// Output register with a skid stage, so that the input side can take one
// more item while a result waits downstream.
// ----------------------------------------------------------------------------
module afd_skid (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    input  afd_pkg::t_result  i_res,
    output logic              o_ready,
    output logic              o_valid,
    output afd_pkg::t_result  o_res,
    input  logic              i_ready
);

    logic             r_valid, n_valid;
    logic             r_skid_valid, n_skid_valid;
    afd_pkg::t_result r_res, n_res;
    afd_pkg::t_result r_skid_res, n_skid_res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid      <= 1'b0;
            r_skid_valid <= 1'b0;
        end else begin
            r_valid      <= n_valid;
            r_skid_valid <= n_skid_valid;
        end
        r_res      <= n_res;
        r_skid_res <= n_skid_res;
    end

    // Refill the output register, park an item in the skid stage on a stall
    always_comb begin
        n_valid      = r_valid;
        n_res        = r_res;
        n_skid_valid = r_skid_valid;
        n_skid_res   = r_skid_res;
        if (!r_valid || i_ready) begin
            if (r_skid_valid) begin
                n_valid      = 1'b1;
                n_res        = r_skid_res;
                n_skid_valid = 1'b0;
            end else begin
                n_valid = i_valid;
                n_res   = i_res;
            end
        end else if (i_valid) begin
            n_skid_valid = 1'b1;
            n_skid_res   = i_res;
        end
    end

    assign o_ready = !r_skid_valid;
    assign o_valid = r_valid;
    assign o_res   = r_res;

endmodule

/* rtl/api_frame_deframer_checksum.sv */
// ----------------------------------------------------------------------------
// api_frame_deframer_checksum
// Deframes modem API frames from a received byte stream and checks the
// 8-bit checksum.
// ----------------------------------------------------------------------------
// One received byte is taken per clock cycle when s_axis_tvalid and
// s_axis_tready are high. Bytes are dropped until the start byte (APB
// register at address 0, reset 0x7E) arrives; the two length bytes, low byte
// first, are consumed silently, and the type, payload and checksum bytes are
// passed on through the output register. The closing byte carries tlast and
// the good flag. Throughput is one byte per cycle while s_axis_tready is high;
// s_axis_tready drops only while both the output register and the skid stage
// hold results that the downstream side has not taken.
module api_frame_deframer_checksum (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // received byte stream
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] in_byte
    // deframed byte stream
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [7:0]  m_axis_tdata,   // [7:0] out_byte
    output logic [2:0]  m_axis_tuser,   // [1:0] kind, [2] good
    output logic        m_axis_tlast,
    // configuration
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    logic             accept;
    logic [7:0]       start_byte;
    logic             res_valid;
    afd_pkg::t_result res;
    afd_pkg::t_result out_res;

    assign accept = s_axis_tvalid && s_axis_tready;

    afd_cfg u_cfg (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready),
        .o_start_byte (start_byte)
    );

    afd_parse u_parse (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_accept     (accept),
        .i_byte       (s_axis_tdata),
        .i_start_byte (start_byte),
        .o_res_valid  (res_valid),
        .o_res        (res)
    );

    afd_skid u_skid (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (res_valid),
        .i_res   (res),
        .o_ready (s_axis_tready),
        .o_valid (m_axis_tvalid),
        .o_res   (out_res),
        .i_ready (m_axis_tready)
    );

    // Pack the result onto the stream fields
    assign m_axis_tdata = out_res.data;
    assign m_axis_tuser = {out_res.good, out_res.kind};
    assign m_axis_tlast = out_res.last;

endmodule

/* rtl/afd_checker.sv */
// ----------------------------------------------------------------------------
// afd_checker
// Port-level checks for the API frame deframer, bound to the top level.
// ----------------------------------------------------------------------------
module afd_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       m_axis_tvalid,
    input logic       m_axis_tready,
    input logic [7:0] m_axis_tdata,
    input logic [2:0] m_axis_tuser,
    input logic       m_axis_tlast
);

    // Hold a stalled result
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser)
            && $stable(m_axis_tlast))
        else $error("stalled result changed");

    // The closing kind and tlast go together
    a_close: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (m_axis_tlast == (m_axis_tuser[1:0] == afd_pkg::KIND_CLOSE)))
        else $error("tlast does not match closing kind");

    // Good only on the closing byte
    a_good: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tlast |-> !m_axis_tuser[2])
        else $error("good flag set on a non-closing byte");

    // No result straight after reset
    a_rst: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("result shown after reset");

endmodule

bind api_frame_deframer_checksum afd_checker u_afd_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
);
